// ----- sv/obm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package obm_pkg;

  typedef enum logic [1:0] {
    OP_BUY    = 2'd0,
    OP_SELL   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_EXEC   = 2'd0,
    KIND_ADDED  = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_ADD,
    ST_CANCEL
  } state_e;

  typedef struct packed {
    opcode_e     op;
    logic [31:0] order_ref;
    logic [7:0]  instrument;
    logic [31:0] price;
    logic [31:0] quantity;
  } cmd_t;

  typedef struct packed {
    logic        is_sell;
    logic [7:0]  instrument;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [31:0] exec_number;
    logic [47:0] added_time;
    logic [31:0] order_ref;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] resting_id;
    logic [31:0] incoming_id;
    logic [31:0] execution_number;
    logic [31:0] deal_price;
    logic [31:0] deal_count;
    logic        accepted;
    logic        sell_side;
    logic [7:0]  instrument_out;
    logic [47:0] stamp;
    logic        last;
  } result_t;

  typedef struct packed {
    logic push;
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- sv/obm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface obm_in_if import obm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] order_ref;
  logic [7:0]  instrument;
  logic [31:0] price;
  logic [31:0] quantity;

  modport source (output valid, opcode, order_ref, instrument, price, quantity, input ready);
  modport sink (input valid, opcode, order_ref, instrument, price, quantity, output ready);
endinterface

interface obm_out_if import obm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] resting_id;
  logic [31:0] incoming_id;
  logic [31:0] execution_number;
  logic [31:0] deal_price;
  logic [31:0] deal_count;
  logic        accepted;
  logic        sell_side;
  logic [7:0]  instrument_out;
  logic [47:0] stamp;
  logic        last;

  modport source (output valid, kind, resting_id, incoming_id, execution_number, deal_price,
                  deal_count, accepted, sell_side, instrument_out, stamp, last,
                  input ready);
  modport sink (input valid, kind, resting_id, incoming_id, execution_number, deal_price,
                deal_count, accepted, sell_side, instrument_out, stamp, last,
                output ready);
endinterface

`default_nettype wire

// ----- sv/obm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module obm_front import obm_pkg::*; (
  obm_in_if.sink     in_i,
  output logic       push_valid_o,
  output cmd_t       push_cmd_o,
  input  logic       push_ready_i
);

  logic keep;

  // Unused opcodes and empty buy or sell orders produce nothing, so they are
  // taken and dropped here.
  always_comb begin
    push_cmd_o.op         = opcode_e'(in_i.opcode);
    push_cmd_o.order_ref  = in_i.order_ref;
    push_cmd_o.instrument = in_i.instrument;
    push_cmd_o.price      = in_i.price;
    push_cmd_o.quantity   = in_i.quantity;
    case (opcode_e'(in_i.opcode))
      OP_BUY, OP_SELL: keep = (in_i.quantity != 32'd0);
      OP_CANCEL:       keep = 1'b1;
      default:         keep = 1'b0;
    endcase
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && keep;

endmodule

`default_nettype wire

// ----- sv/obm_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module obm_fifo import obm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  cmd_t       push_cmd_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output cmd_t       pop_cmd_o,
  input  logic       pop_ready_i,
  output fifo_stat_t stat_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  assign stat_o.push  = push;
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

// ----- sv/obm_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module obm_engine import obm_pkg::*; #(
  parameter int BOOK_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_ready_o,
  obm_out_if.source   out_o
);

  localparam int AW = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
  localparam int IW = $clog2(BOOK_ENTRIES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(BOOK_ENTRIES);

  state_e  state_q, state_d;
  cmd_t    cmd_q;
  logic [31:0] qty_q;
  logic [IW-1:0] idx_q;
  logic [AW-1:0] cmp_idx_q, best_idx_q, free_idx_q;
  logic    cmp_en_q, best_found_q, free_found_q, found_q;
  entry_t  rd_q, best_q;
  logic [BOOK_ENTRIES-1:0] valid_q, valid_d;
  logic [47:0] stamp_q;
  logic    out_valid_q;
  result_t out_q, res;

  entry_t  book_mem [BOOK_ENTRIES];
  logic    mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t  mem_wdata;

  logic out_free, emit, scan_done, start_scan, rest_sell, rd_vld;
  logic elig, crosses, beats, take, id_hit;
  logic [31:0] fill, rem_left, qty_left;

  assign out_free  = !out_valid_q || out_o.ready;
  assign scan_done = (idx_q == LastIdx) && !cmp_en_q;
  assign rest_sell = (cmd_q.op == OP_BUY);
  assign rd_vld    = valid_q[cmp_idx_q];
  assign id_hit    = cmp_en_q && rd_vld && (rd_q.order_ref == cmd_q.order_ref);

  always_comb begin
    crosses = rest_sell ? (rd_q.price <= cmd_q.price) : (rd_q.price >= cmd_q.price);
    elig    = (state_q == ST_SCAN) && cmp_en_q && rd_vld && (rd_q.is_sell == rest_sell) &&
              (rd_q.instrument == cmd_q.instrument) && crosses;
    if (rd_q.price != best_q.price) begin
      beats = rest_sell ? (rd_q.price < best_q.price) : (rd_q.price > best_q.price);
    end else if (rd_q.added_time != best_q.added_time) begin
      beats = rd_q.added_time < best_q.added_time;
    end else begin
      beats = rd_q.order_ref < best_q.order_ref;
    end
    take     = elig && (!best_found_q || beats);
    fill     = (qty_q < best_q.remaining) ? qty_q : best_q.remaining;
    rem_left = best_q.remaining - fill;
    qty_left = qty_q - fill;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (cmd_q.op == OP_CANCEL) state_d = ST_CANCEL;
          else if (best_found_q) state_d = ST_FILL;
          else state_d = ST_ADD;
        end
      end
      ST_FILL: begin
        if (out_free) state_d = (qty_left == 32'd0) ? ST_IDLE : ST_SCAN;
      end
      ST_ADD, ST_CANCEL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs, book writes and valid bit updates.
  always_comb begin
    cmd_ready_o = (state_q == ST_IDLE);
    emit        = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = best_idx_q;
    mem_wdata   = best_q;
    valid_d     = valid_q;
    res         = '0;
    res.stamp   = stamp_q;
    res.last    = 1'b1;
    start_scan  = (state_q == ST_IDLE) && cmd_valid_i;
    case (state_q)
      ST_SCAN: begin
        if (cmd_q.op == OP_CANCEL && id_hit) valid_d[cmp_idx_q] = 1'b0;
      end
      ST_FILL: begin
        emit                  = out_free;
        res.kind              = KIND_EXEC;
        res.resting_id        = best_q.order_ref;
        res.incoming_id       = cmd_q.order_ref;
        res.execution_number  = best_q.exec_number;
        res.deal_price        = best_q.price;
        res.deal_count        = fill;
        res.last              = (qty_left == 32'd0);
        mem_we                = out_free;
        mem_wdata.remaining   = rem_left;
        mem_wdata.exec_number = best_q.exec_number + 32'd1;
        if (out_free && rem_left == 32'd0) valid_d[best_idx_q] = 1'b0;
        start_scan = out_free && (qty_left != 32'd0);
      end
      ST_ADD: begin
        emit                  = out_free;
        res.kind              = KIND_ADDED;
        res.resting_id        = cmd_q.order_ref;
        res.deal_price        = cmd_q.price;
        res.deal_count        = qty_q;
        res.accepted          = free_found_q;
        res.sell_side         = (cmd_q.op == OP_SELL);
        res.instrument_out    = cmd_q.instrument;
        mem_we                = out_free && free_found_q;
        mem_waddr             = free_idx_q;
        mem_wdata.is_sell     = (cmd_q.op == OP_SELL);
        mem_wdata.instrument  = cmd_q.instrument;
        mem_wdata.price       = cmd_q.price;
        mem_wdata.remaining   = qty_q;
        mem_wdata.exec_number = 32'd1;
        mem_wdata.added_time  = stamp_q;
        mem_wdata.order_ref   = cmd_q.order_ref;
        if (out_free && free_found_q) valid_d[free_idx_q] = 1'b1;
      end
      ST_CANCEL: begin
        emit           = out_free;
        res.kind       = KIND_CANCEL;
        res.resting_id = cmd_q.order_ref;
        res.accepted   = found_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      stamp_q      <= '0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      cmp_en_q     <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= emit || (out_valid_q && !out_o.ready);
      if (emit) stamp_q <= stamp_q + 48'd1;
      if (start_scan) begin
        idx_q        <= '0;
        cmp_en_q     <= 1'b0;
        best_found_q <= 1'b0;
        free_found_q <= 1'b0;
        found_q      <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (idx_q != LastIdx) begin
          idx_q    <= idx_q + IW'(1);
          cmp_en_q <= 1'b1;
        end else begin
          cmp_en_q <= 1'b0;
        end
        if (take) best_found_q <= 1'b1;
        if (cmp_en_q && !rd_vld) free_found_q <= 1'b1;
        if (id_hit) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= book_mem[idx_q[AW-1:0]];
    if (mem_we) book_mem[mem_waddr] <= mem_wdata;
    if (emit) out_q <= res;
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
      qty_q <= cmd_i.quantity;
    end else if (state_q == ST_FILL && out_free) begin
      qty_q <= qty_left;
    end
    if (state_q == ST_SCAN) begin
      cmp_idx_q <= idx_q[AW-1:0];
      if (take) begin
        best_q     <= rd_q;
        best_idx_q <= cmp_idx_q;
      end
      if (cmp_en_q && !rd_vld && !free_found_q) free_idx_q <= cmp_idx_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = out_q.kind;
  assign out_o.resting_id       = out_q.resting_id;
  assign out_o.incoming_id      = out_q.incoming_id;
  assign out_o.execution_number = out_q.execution_number;
  assign out_o.deal_price       = out_q.deal_price;
  assign out_o.deal_count       = out_q.deal_count;
  assign out_o.accepted         = out_q.accepted;
  assign out_o.sell_side        = out_q.sell_side;
  assign out_o.instrument_out   = out_q.instrument_out;
  assign out_o.stamp            = out_q.stamp;
  assign out_o.last             = out_q.last;

endmodule

`default_nettype wire

// ----- sv/order_book_matcher_core.sv -----
// Flow: a cancel takes one search over the book from dequeue to its result; a buy or sell
// takes one search per fill, plus a final search and add when quantity remains after them.
// Throughput: one item at a time; the search over the book, one entry per cycle through
// the single read port of the book memory, sets the figure. Up to two items wait queued.
// Reset: asynchronous, active low; clears all entry valid bits, the stamp counter and the
// queue. No clearing pass is needed, so items are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module order_book_matcher_core import obm_pkg::*; #(
  parameter int BOOK_ENTRIES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  obm_in_if.sink     in_i,
  obm_out_if.source  out_o
);

  // The front classifies each incoming item and drops those that cause no result
  // (the unused opcode, and buy or sell with zero quantity).
  logic       push_valid, push_ready, pop_valid, pop_ready;
  cmd_t       push_cmd, pop_cmd;
  fifo_stat_t fifo_stat;

  obm_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  // A two-entry queue lets the front keep taking items while the back end
  // searches the book or waits on a stalled output.
  obm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready),
    .stat_o       (fifo_stat)
  );

  // The back end scans the book for the best crossing order, fills against it,
  // rests any remainder in the lowest free slot, and handles cancels. Results
  // leave through an output register, so the engine only stalls when a result
  // is still waiting there.
  obm_engine #(
    .BOOK_ENTRIES (BOOK_ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // A cancel always produces exactly one result, so it must be the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_CANCEL) |-> out_o.last)
    else $error("cancel result without last");

  // Executions never carry the accepted or sell flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_EXEC) |-> (!out_o.accepted && !out_o.sell_side))
    else $error("execution result carries add flags");

  // The queue never takes an item while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.push |-> !fifo_stat.full)
    else $error("queue overflow");

  // Results after a delivered one carry the next stamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) ##1 out_o.valid |-> out_o.stamp == $past(out_o.stamp) + 48'd1)
    else $error("stamp sequence broken");
`endif

endmodule

`default_nettype wire
